FILE: design/fsw_pkg.sv
// ----------------------------------------------------------------------------
// fsw_pkg: shared definitions of the windowed strict minimum detector
// Sizes, register indexes, state codes, the probe broadcast to the cells and
// the window saturation helper.
// ----------------------------------------------------------------------------
package fsw_pkg;

    localparam int unsigned MAX_BEFORE  = 7;
    localparam int unsigned MAX_AFTER   = 7;
    localparam int unsigned MAX_LENGTH  = 65536;
    localparam int unsigned SAMPLE_BITS = 30;

    // Number of cells in the history chain.
    localparam int unsigned DEPTH      = MAX_BEFORE + MAX_AFTER + 1;
    localparam int unsigned OFF_BITS   = $clog2(DEPTH);
    localparam int unsigned COUNT_BITS = $clog2(MAX_LENGTH + 1);
    localparam int unsigned POS_BITS   = 17;
    localparam int unsigned WIN_BITS   = 3;
    localparam int unsigned DATA_BITS  = 32;
    localparam int unsigned ADDR_BITS  = 3;

    typedef enum logic {
        REG_WINDOW_BEFORE = 1'b0,
        REG_WINDOW_AFTER  = 1'b1
    } t_reg_idx;

    typedef enum logic {
        ST_RUN   = 1'b0,
        ST_FLUSH = 1'b1
    } t_state;

    // Everything a cell needs to decide whether it defeats the candidate.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] cand;
        logic [OFF_BITS-1:0]    k;
        logic [OFF_BITS-1:0]    wa;
        logic [OFF_BITS-1:0]    wb;
        logic [OFF_BITS-1:0]    lim;
    } t_probe;

    // Clamp a window register to its maximum.
    function automatic logic [OFF_BITS-1:0] sat_win(input logic [WIN_BITS-1:0] w,
                                                    input int unsigned         m);
        logic [OFF_BITS-1:0] r;
        if (int'(w) > int'(m)) begin
            r = OFF_BITS'(m);
        end else begin
            r = OFF_BITS'(w);
        end
        return r;
    endfunction

endpackage

FILE: design/fsw_in_if.sv
// ----------------------------------------------------------------------------
// fsw_in_if: sample channel
// Valid/ready channel carrying one sample and its end-of-stream flag.
// ----------------------------------------------------------------------------
interface fsw_in_if
    import fsw_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

FILE: design/fsw_out_if.sv
// ----------------------------------------------------------------------------
// fsw_out_if: result channel
// Valid/ready channel carrying one result per stream.
// ----------------------------------------------------------------------------
interface fsw_out_if
    import fsw_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                found;
    logic [POS_BITS-1:0] position;

    modport source (output valid, output found, output position, input ready);
    modport sink   (input valid, input found, input position, output ready);
endinterface

FILE: design/fsw_apb_regs.sv
// ----------------------------------------------------------------------------
// fsw_apb_regs: configuration registers
// APB-style write and read decode of the two window registers.
// ----------------------------------------------------------------------------
module fsw_apb_regs
    import fsw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output logic [WIN_BITS-1:0]  o_wb,
    output logic [WIN_BITS-1:0]  o_wa
);

    logic [WIN_BITS-1:0] r_wb;
    logic [WIN_BITS-1:0] r_wa;
    t_reg_idx            w_idx;
    logic                w_wr;

    assign w_idx  = t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb <= '0;
            r_wa <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_WINDOW_BEFORE: r_wb <= pwdata[WIN_BITS-1:0];
                REG_WINDOW_AFTER:  r_wa <= pwdata[WIN_BITS-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_WINDOW_BEFORE: prdata = DATA_BITS'(r_wb);
            REG_WINDOW_AFTER:  prdata = DATA_BITS'(r_wa);
        endcase
    end

    assign o_wb = r_wb;
    assign o_wa = r_wa;

endmodule

FILE: design/fsw_cell.sv
// ----------------------------------------------------------------------------
// fsw_cell: one history cell
// Holds one sample, passes it on to the next cell on a shift, and flags
// whether it lies in the candidate's windows and is not beaten by it.
// ----------------------------------------------------------------------------
module fsw_cell
    import fsw_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_shift,
    input  logic [OFF_BITS-1:0]    i_idx,
    input  logic [SAMPLE_BITS-1:0] i_data,
    input  t_probe                 i_probe,
    output logic [SAMPLE_BITS-1:0] o_data,
    output logic                   o_fail
);

    logic [SAMPLE_BITS-1:0] r_data;
    logic [OFF_BITS:0]      w_hi;
    logic                   w_later_ok;
    logic                   w_in_win;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    // Cells below the candidate hold later samples, cells above earlier ones.
    assign w_hi       = {1'b0, i_probe.k} + {1'b0, i_probe.wb};
    assign w_later_ok = (i_idx >= i_probe.k) || ((i_probe.k - i_idx) <= i_probe.wa);
    assign w_in_win   = (i_idx != i_probe.k) && w_later_ok
                        && ({1'b0, i_idx} <= w_hi) && (i_idx < i_probe.lim);
    assign o_fail     = w_in_win && (r_data <= i_probe.cand);
    assign o_data     = r_data;

endmodule

FILE: design/first_windowed_strict_minimum_core.sv
// ----------------------------------------------------------------------------
// first_windowed_strict_minimum_core: first windowed strict minimum detector
// Finds, per stream, the first sample strictly below its neighbours within
// the configured earlier and later windows.
// ----------------------------------------------------------------------------
// Use: samples enter on i_smp, the last of a stream flagged; one result per
// stream leaves on o_res (found and 1-based position, or not found with
// position 0). The user must write the window registers over the APB port
// only while the block is idle; the block itself does not enforce this.
// Throughput: one sample a cycle while i_smp.ready is high. A sample shifts
// into the cell chain on the cycle it is accepted and its candidate is judged
// from the check register; a hit is then registered in the output register.
// The last sample of an undecided stream closes it with a flush that judges
// the pending candidates one per cycle while the output register is free,
// during which i_smp.ready is low.
// Stalls: the result sits in an output register, so samples keep being
// taken while it waits; a full output register lowers i_smp.ready only when
// a further judgement is due, until the receiver takes the result.
// Reset: synchronous and active low; clears the sample count, the stream
// state and the output; windows return to zero. The history cells are not
// cleared, as only cells of the current stream are ever compared.
// ----------------------------------------------------------------------------
module first_windowed_strict_minimum_core
    import fsw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    fsw_in_if.sink               i_smp,
    fsw_out_if.source            o_res,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    // Configuration.
    logic [WIN_BITS-1:0] w_cfg_wb;
    logic [WIN_BITS-1:0] w_cfg_wa;
    logic [OFF_BITS-1:0] w_wb;
    logic [OFF_BITS-1:0] w_wa;

    fsw_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_wb    (w_cfg_wb),
        .o_wa    (w_cfg_wa)
    );

    assign w_wb = sat_win(w_cfg_wb, MAX_BEFORE);
    assign w_wa = sat_win(w_cfg_wa, MAX_AFTER);

    // Stream and control state.
    t_state                r_state, n_state;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_decided, n_decided;
    logic                  r_chk_valid, n_chk_valid;
    logic                  r_chk_last, n_chk_last;
    logic                  r_chk_fresh, n_chk_fresh;
    logic [OFF_BITS-1:0]   r_k, n_k;
    logic                  r_empty, n_empty;
    logic                  r_out_valid, n_out_valid;
    logic                  r_found, n_found;
    logic [POS_BITS-1:0]   r_pos, n_pos;

    // Cell chain.
    logic [SAMPLE_BITS-1:0] w_data [DEPTH];
    logic [DEPTH-1:0]       w_fail;
    t_probe                 w_probe;
    logic [OFF_BITS-1:0]    w_k_sel;
    logic [OFF_BITS-1:0]    w_lim;
    logic                   w_qual;

    // Handshake and decision terms.
    logic                  w_out_busy;
    logic                  w_chk_hit;
    logic                  w_chk_stall;
    logic                  w_in_ready;
    logic                  w_accept;
    logic                  w_dec_eff;
    logic                  w_fresh_now;
    logic                  w_shift;
    logic [COUNT_BITS-1:0] w_p_m1;
    logic [OFF_BITS-1:0]   w_wa_t;
    logic [OFF_BITS-1:0]   w_k_start;

    // The candidate sits wa cells down the chain while streaming; during the
    // flush a counter walks the pending candidates from oldest to newest.
    assign w_k_sel = (r_state == ST_FLUSH) ? r_k : w_wa;
    assign w_lim   = (r_count >= COUNT_BITS'(DEPTH)) ? OFF_BITS'(DEPTH)
                                                     : r_count[OFF_BITS-1:0];

    assign w_probe.cand = w_data[w_k_sel];
    assign w_probe.k    = w_k_sel;
    assign w_probe.wa   = w_wa;
    assign w_probe.wb   = w_wb;
    assign w_probe.lim  = w_lim;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [SAMPLE_BITS-1:0] w_in;
        if (g == 0) begin : g_head
            assign w_in = i_smp.sample;
        end else begin : g_body
            assign w_in = w_data[g-1];
        end
        fsw_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_idx   (OFF_BITS'(g)),
            .i_data  (w_in),
            .i_probe (w_probe),
            .o_data  (w_data[g]),
            .o_fail  (w_fail[g])
        );
    end

    // A candidate qualifies when no cell in its windows is at or below it.
    assign w_qual = ~|w_fail;

    assign w_out_busy  = r_out_valid && !o_res.ready;
    assign w_chk_hit   = r_chk_valid && !r_chk_last && r_chk_fresh
                         && (r_count > COUNT_BITS'(w_wa)) && w_qual;
    assign w_chk_stall = r_chk_valid && w_out_busy;
    assign w_in_ready  = (r_state == ST_RUN) && !w_chk_stall
                         && !(r_chk_valid && r_chk_last);
    assign w_accept    = i_smp.valid && w_in_ready;
    // The judgement of the previous sample happens in the same cycle as the
    // acceptance of this one, so its hit already counts as decided.
    assign w_dec_eff   = r_decided || w_chk_hit;
    assign w_fresh_now = r_count < COUNT_BITS'(MAX_LENGTH);
    assign w_shift     = w_accept && !w_dec_eff && w_fresh_now;

    // First flush candidate: the one whose later window has just filled when
    // the last sample was new, else the one after it. With no new sample and
    // an empty later window there is nothing left to judge.
    assign w_p_m1    = r_count - COUNT_BITS'(1);
    assign w_wa_t    = r_chk_fresh ? w_wa : (w_wa - OFF_BITS'(1));
    assign w_k_start = (w_p_m1 < COUNT_BITS'(w_wa_t)) ? w_p_m1[OFF_BITS-1:0] : w_wa_t;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_decided   = r_decided;
        n_chk_valid = r_chk_valid;
        n_chk_last  = r_chk_last;
        n_chk_fresh = r_chk_fresh;
        n_k         = r_k;
        n_empty     = r_empty;
        n_out_valid = r_out_valid && !o_res.ready;
        n_found     = r_found;
        n_pos       = r_pos;

        unique case (r_state)
            ST_RUN: begin
                if (r_chk_valid && !w_chk_stall) begin
                    n_chk_valid = 1'b0;
                    if (r_chk_last) begin
                        n_state = ST_FLUSH;
                        n_k     = w_k_start;
                        n_empty = !r_chk_fresh && (w_wa == '0);
                    end else if (w_chk_hit) begin
                        n_out_valid = 1'b1;
                        n_found     = 1'b1;
                        n_pos       = POS_BITS'(r_count - COUNT_BITS'(w_k_sel));
                        n_decided   = 1'b1;
                    end
                end
                if (w_accept) begin
                    if (w_dec_eff) begin
                        // Stream already answered: only its end matters.
                        if (i_smp.last) begin
                            n_count   = '0;
                            n_decided = 1'b0;
                        end
                    end else begin
                        if (w_fresh_now) begin
                            n_count = r_count + COUNT_BITS'(1);
                        end
                        n_chk_valid = 1'b1;
                        n_chk_last  = i_smp.last;
                        n_chk_fresh = w_fresh_now;
                    end
                end
            end
            ST_FLUSH: begin
                if (!w_out_busy) begin
                    if (!r_empty && !w_qual && (r_k != '0)) begin
                        n_k = r_k - OFF_BITS'(1);
                    end else begin
                        n_out_valid = 1'b1;
                        n_found     = !r_empty && w_qual;
                        n_pos       = (!r_empty && w_qual)
                                      ? POS_BITS'(r_count - COUNT_BITS'(r_k)) : '0;
                        n_state     = ST_RUN;
                        n_count     = '0;
                        n_decided   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_decided   <= 1'b0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_decided   <= n_decided;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_last  <= n_chk_last;
        r_chk_fresh <= n_chk_fresh;
        r_k         <= n_k;
        r_empty     <= n_empty;
        r_found     <= n_found;
        r_pos       <= n_pos;
    end

    assign i_smp.ready    = w_in_ready;
    assign o_res.valid    = r_out_valid;
    assign o_res.found    = r_found;
    assign o_res.position = r_pos;

`ifndef SYNTH
    // No sample may enter the chain while the flush walks it.
    a_no_accept_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> !i_smp.ready)
        else $error("sample accepted during flush");

    // A flush is only entered for a stream that has no answer yet.
    a_flush_undecided: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> !r_decided)
        else $error("flush of an already decided stream");

    // A not-found result always carries position zero.
    a_miss_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_found) |-> (r_pos == '0))
        else $error("not-found result with non-zero position");

    // A hit is a 1-based position.
    a_hit_pos_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_found) |-> (r_pos != '0))
        else $error("hit reported at position zero");

    // The sample count stops at the stream length limit.
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_BITS'(MAX_LENGTH))
        else $error("sample count beyond the length limit");
`endif

endmodule

FILE: sim/fsw_minimum_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsw_minimum_monitor: expected-minimum predictor and result comparator
// Watches the sample, result and register channels of the detector. It works
// out the result of every stream and compares each result transaction with
// the oldest expectation waiting.
// ----------------------------------------------------------------------------
module fsw_minimum_monitor
    import fsw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    fsw_in_if                    i_smp,
    fsw_out_if                   i_res,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    input  logic [DATA_BITS-1:0] prdata,
    input  logic                 pready,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic                found;
        logic [POS_BITS-1:0] position;
    } t_minimum;

    t_minimum               expected_minima[$];
    t_minimum               oldest_minimum;
    logic [SAMPLE_BITS-1:0] sample_ring [DEPTH];
    int unsigned            stream_len;
    bit                     stream_done;
    logic [WIN_BITS-1:0]    win_before;
    logic [WIN_BITS-1:0]    win_after;
    logic [DATA_BITS-1:0]   reg_value;
    int                     fails = 0;

    task automatic note_mismatch(input string what);
        fails++;
        if (fails <= 10) begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
    endtask

    // True when the candidate is strictly below every stored sample of its
    // two windows, both clipped to the stream so far.
    function automatic bit is_strict_minimum(input int unsigned cand,
                                             input int unsigned stop,
                                             input int unsigned wb,
                                             input int unsigned wa);
        int unsigned            lo;
        int unsigned            hi;
        int unsigned            j;
        logic [SAMPLE_BITS-1:0] v;
        lo = (cand > wb) ? cand - wb : 1;
        hi = (cand + wa > stop) ? stop : cand + wa;
        v  = sample_ring[cand % DEPTH];
        for (j = lo; j <= hi; j++) begin
            if (j != cand && sample_ring[j % DEPTH] <= v) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic predict_minimum(input logic [SAMPLE_BITS-1:0] value,
                                   input logic                   is_last);
        int unsigned wb;
        int unsigned wa;
        int unsigned p;
        int unsigned hit;
        int unsigned c;
        int unsigned first;
        bit          fresh;
        t_minimum    r;
        if (!stream_done) begin
            wb    = (win_before < MAX_BEFORE) ? win_before : MAX_BEFORE;
            wa    = (win_after < MAX_AFTER) ? win_after : MAX_AFTER;
            fresh = 1'b0;
            hit   = 0;
            if (stream_len < MAX_LENGTH) begin
                stream_len++;
                sample_ring[stream_len % DEPTH] = value;
                fresh = 1'b1;
            end
            p = stream_len;
            if (!is_last) begin
                if (fresh && p > wa && is_strict_minimum(p - wa, p, wb, wa)) begin
                    hit = p - wa;
                end
            end else begin
                // Closing flush: every candidate not yet judged, oldest first.
                if (p > wa) begin
                    first = fresh ? p - wa : p - wa + 1;
                end else begin
                    first = 1;
                end
                for (c = first; c <= p && hit == 0; c++) begin
                    if (is_strict_minimum(c, p, wb, wa)) begin
                        hit = c;
                    end
                end
            end
            if (hit != 0) begin
                r.found    = 1'b1;
                r.position = POS_BITS'(hit);
                expected_minima.push_back(r);
                stream_done = 1'b1;
            end else if (is_last) begin
                r = '0;
                expected_minima.push_back(r);
            end
        end
        if (is_last) begin
            stream_len  = 0;
            stream_done = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stream_len  = 0;
            stream_done = 1'b0;
            win_before  = '0;
            win_after   = '0;
            expected_minima.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[ADDR_BITS-1:2] == REG_WINDOW_BEFORE) begin
                        win_before = pwdata[WIN_BITS-1:0];
                    end else begin
                        win_after = pwdata[WIN_BITS-1:0];
                    end
                end else begin
                    if (paddr[ADDR_BITS-1:2] == REG_WINDOW_BEFORE) begin
                        reg_value = DATA_BITS'(win_before);
                    end else begin
                        reg_value = DATA_BITS'(win_after);
                    end
                    if (prdata !== reg_value) begin
                        note_mismatch($sformatf("read of 0x%0h: expected 0x%0h, got 0x%0h",
                                                paddr, reg_value, prdata));
                    end
                end
            end
            if (i_smp.valid === 1'b1 && i_smp.ready === 1'b1) begin
                predict_minimum(i_smp.sample, i_smp.last);
            end
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) begin
                if (expected_minima.size() == 0) begin
                    note_mismatch($sformatf("unexpected result found=%b position=%0d",
                                            i_res.found, i_res.position));
                end else begin
                    oldest_minimum = expected_minima.pop_front();
                    if (i_res.found !== oldest_minimum.found) begin
                        note_mismatch($sformatf("found: expected %b, got %b",
                                                oldest_minimum.found, i_res.found));
                    end
                    if (i_res.position !== oldest_minimum.position) begin
                        note_mismatch($sformatf("position: expected %0d, got %0d",
                                                oldest_minimum.position, i_res.position));
                    end
                end
            end
        end
        o_fail_count = fails;
        o_pending    = expected_minima.size();
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the windowed strict minimum detector
// Drives sample streams and window settings into the detector, with random
// idling on both channels, and leaves prediction and comparison to the
// monitor beside it. A short directed part is followed by random phases of
// streams.
// ----------------------------------------------------------------------------
module tb_top
    import fsw_pkg::*;
;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
    localparam int unsigned RANDOM_ITEMS  = 1530;
    // The settle time lets the longest flush after a last sample run out; the
    // margin covers the output register as well.
    localparam int unsigned SETTLE_CYCLES = MAX_AFTER + 6;
    localparam int unsigned DRAIN_LIMIT   = 2000;

    // Shapes of random stream content.
    typedef enum int unsigned {
        SHAPE_VALLEY,
        SHAPE_TIES,
        SHAPE_WIDE,
        SHAPE_EDGES
    } t_shape;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;
    int                   fail_count;
    int                   pending;

    // Idling controls: idle_en switches idling on both sides, gap_pct is the
    // chance (in percent) that a sample transaction is preceded by a gap.
    bit                   idle_en;
    int unsigned          gap_pct;
    int unsigned          items_sent;
    int unsigned          random_start;
    int unsigned          loop_i;
    int unsigned          stream_count;
    int unsigned          wait_cycles;

    fsw_in_if  smp_if ();
    fsw_out_if res_if ();

    first_windowed_strict_minimum_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    fsw_minimum_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_smp        (smp_if),
        .i_res        (res_if),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: several times the slowest correct run.
    initial begin
        #10_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // Result receiver. While idling is enabled it stalls in random bursts
    // between stretches of readiness; otherwise it always accepts. Each step
    // carries a single assignment to ready.
    initial begin
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) begin
            @(posedge i_clk);
        end
        forever begin
            if (idle_en && $urandom_range(0, 2) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    // Offers one sample and returns at the edge where the transaction is
    // accepted. Valid is left high, so back-to-back samples need no second
    // assignment in the same step; a gap lowers it for a whole burst first.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value,
                               input logic                   is_last);
        if (idle_en && $urandom_range(0, 99) < gap_pct) begin
            smp_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        smp_if.valid  <= 1'b1;
        smp_if.sample <= value;
        smp_if.last   <= is_last;
        do begin
            @(posedge i_clk);
        end while (smp_if.ready !== 1'b1);
        items_sent++;
    endtask

    // Stops offering samples and waits until every expected result has been
    // taken, then lets the longest flush run out, so that the detector is
    // idle before the registers are touched.
    task automatic drain_results();
        smp_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register access: a setup phase, then the access phase that
    // completes at the edge where pready is high. An idle phase follows so
    // that psel is never lowered and raised in the same step.
    task automatic reg_access(input bit                   is_write,
                              input t_reg_idx             idx,
                              input logic [DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= ADDR_BITS'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes both windows once the detector is idle and reads them back; the
    // monitor checks the read data against its own copy.
    task automatic set_windows(input int unsigned before_w, input int unsigned after_w);
        drain_results();
        reg_access(1'b1, REG_WINDOW_BEFORE, DATA_BITS'(before_w));
        reg_access(1'b1, REG_WINDOW_AFTER, DATA_BITS'(after_w));
        reg_access(1'b0, REG_WINDOW_BEFORE, '0);
        reg_access(1'b0, REG_WINDOW_AFTER, '0);
    endtask

    // Picks a window width, leaning towards the two extremes.
    function automatic int unsigned pick_window();
        int unsigned r;
        r = $urandom_range(0, 3);
        if (r == 0) begin
            return 0;
        end else if (r == 1) begin
            return 7;
        end
        return $urandom_range(0, 7);
    endfunction

    // Sends one whole stream of the given length. Valleys are the well-formed
    // case: values fall towards a dip and rise again, with a little noise so
    // that ties appear. The other shapes are noise with many ties, full-range
    // values and values at the two extremes of the field.
    task automatic send_stream(input int unsigned len, input t_shape shape);
        int unsigned            dip;
        int unsigned            base;
        int unsigned            slope;
        int unsigned            i;
        logic [SAMPLE_BITS-1:0] v;
        dip   = $urandom_range(0, len - 1);
        base  = $urandom_range(0, 1 << 20);
        slope = $urandom_range(0, 3);
        for (i = 0; i < len; i++) begin
            case (shape)
                SHAPE_TIES: begin
                    v = SAMPLE_BITS'($urandom_range(0, 7));
                end
                SHAPE_WIDE: begin
                    v = SAMPLE_BITS'($urandom());
                end
                SHAPE_EDGES: begin
                    v = ($urandom_range(0, 1) == 1) ? SAMPLE_MAX - SAMPLE_BITS'($urandom_range(0, 1))
                                                    : SAMPLE_BITS'($urandom_range(0, 1));
                end
                default: begin
                    v = SAMPLE_BITS'(base + ((i > dip) ? i - dip : dip - i) * slope
                                     + $urandom_range(0, 1));
                end
            endcase
            send_sample(v, i == len - 1);
        end
    endtask

    initial begin
        // Every input is known from time zero.
        i_rst_n       <= 1'b0;
        smp_if.valid  <= 1'b0;
        smp_if.sample <= '0;
        smp_if.last   <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        idle_en        = 1'b0;
        gap_pct        = 0;
        items_sent     = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---------------------------------------------------------------
        // Directed part
        // ---------------------------------------------------------------
        idle_en = 1'b1;
        gap_pct = 30;

        // Windows at their reset value of zero: the first sample has two
        // empty windows and is a hit at once; the last sample is ignored.
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample('0, 1'b1);

        // Widest windows over equal samples: nothing is strictly lower, so
        // the stream ends with not-found.
        set_windows(7, 7);
        send_sample(5, 1'b0);
        send_sample(5, 1'b0);
        send_sample(5, 1'b1);

        // A dip at position 3 is decided as soon as its later window has
        // arrived; the rest of the stream, last sample included, is ignored.
        set_windows(2, 1);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(6, 1'b0);
        send_sample(2, 1'b0);
        send_sample(9, 1'b0);
        send_sample(4, 1'b1);

        // Windows changed part way through a stream: the candidate judged
        // after the change uses the new later window of zero.
        send_sample(4, 1'b0);
        send_sample(4, 1'b0);
        set_windows(2, 0);
        send_sample(3, 1'b0);
        send_sample('0, 1'b1);

        // A later window longer than the stream: the decision falls to the
        // closing flush, which finds position 1.
        set_windows(0, 7);
        send_sample(1, 1'b0);
        send_sample(2, 1'b0);
        send_sample(3, 1'b1);

        // A flush over several candidates that all fail.
        set_windows(7, 2);
        send_sample(8, 1'b0);
        send_sample(8, 1'b0);
        send_sample(8, 1'b0);
        send_sample(8, 1'b1);

        // ---------------------------------------------------------------
        // Random phases: each sets both windows while idle, picks an idling
        // level and sends a handful of streams back to back. The last fifth
        // runs without idling on either side.
        // ---------------------------------------------------------------
        random_start = items_sent;
        idle_en      = 1'b1;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            if (items_sent - random_start > (RANDOM_ITEMS * 4) / 5) begin
                idle_en = 1'b0;
            end
            set_windows(pick_window(), pick_window());
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 15;
                default: gap_pct = 50;
            endcase
            stream_count = $urandom_range(1, 6);
            repeat (stream_count) begin
                loop_i = $urandom_range(0, 9);
                send_stream(($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
                                                        : $urandom_range(1, 12),
                            (loop_i < 5) ? SHAPE_VALLEY :
                            (loop_i < 7) ? SHAPE_TIES   :
                            (loop_i < 9) ? SHAPE_WIDE   : SHAPE_EDGES);
            end
        end

        // ---------------------------------------------------------------
        // End of run: wait, within a bound, for the last results, let the
        // detector settle, then give the verdict.
        // ---------------------------------------------------------------
        idle_en = 1'b0;
        smp_if.valid <= 1'b0;
        @(posedge i_clk);
        for (wait_cycles = 0; pending != 0 && wait_cycles < DRAIN_LIMIT; wait_cycles++) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/fsw_pkg.sv
design/fsw_in_if.sv
design/fsw_out_if.sv
design/fsw_apb_regs.sv
design/fsw_cell.sv
design/first_windowed_strict_minimum_core.sv
sim/fsw_minimum_monitor.sv
sim/tb_top.sv
